>>> rtl/cic_charge_deposit_1d_top_assert.svh
// Assertion macros for the cloud-in-cell charge deposition block.
// Included by the top level; depends on nothing else.
`ifndef CIC_CHARGE_DEPOSIT_1D_TOP_ASSERT_SVH
`define CIC_CHARGE_DEPOSIT_1D_TOP_ASSERT_SVH
`ifndef SYNTH
// Antecedent in one cycle implies the consequent in the next cycle.
`define CCD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
// Antecedent implies the consequent in the same cycle.
`define CCD_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`else
`define CCD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`define CCD_ASSERT_SAME(label, clk, rst_n, ante, cons, msg)
`endif
`endif

>>> rtl/ccd_pkg.sv
// Shared types, codes and constants for the charge deposition block.
// Used by the density RAM and the top level; depends on nothing else.
`default_nettype none

package ccd_pkg;

    // Bin width and limits, signed Q32.16.
    localparam int BIN_W = 48;
    localparam logic [BIN_W-1:0] BIN_MAX = 48'h7FFF_FFFF_FFFF;
    localparam logic [BIN_W-1:0] BIN_MIN = 48'h8000_0000_0000;

    // Default grid size.
    localparam int GRID_CELLS_DEF = 1024;

    // Commands.
    typedef enum logic [1:0] {
        CMD_CLEAR   = 2'd0,
        CMD_DEPOSIT = 2'd1,
        CMD_READ    = 2'd2,
        CMD_NOP     = 2'd3
    } t_cmd;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_CELLS_IN_USE  = 2'd0,
        CFG_INV_CELL_W    = 2'd1,
        CFG_SYSTEM_LENGTH = 2'd2,
        CFG_UNUSED        = 2'd3
    } t_cfg_index;

    // Status codes.
    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_DROPPED = 1'b1;

    // Configuration reset values.
    localparam logic [10:0] CELLS_RST = 11'd1024;
    localparam logic [31:0] INV_W_RST = 32'd65536;
    localparam logic [30:0] SLEN_RST  = 31'd67108864;

    // Saturating addition of a signed amount to a bin.
    function automatic logic [BIN_W-1:0] sat_add(input logic [BIN_W-1:0] a,
                                                 input logic [33:0] b);
        logic [BIN_W:0] s;
        s = {a[BIN_W-1], a} + {{(BIN_W-33){b[33]}}, b};
        if (s[BIN_W] != s[BIN_W-1]) begin
            return s[BIN_W] ? BIN_MIN : BIN_MAX;
        end
        return s[BIN_W-1:0];
    endfunction

endpackage

`default_nettype wire

>>> rtl/cic_charge_deposit_1d_top.sv
// Top level of the cloud-in-cell charge deposition block on a periodic 1D grid.
// Depends on ccd_pkg, ccd_density_ram and the assertion macro header.
`default_nettype none

// One transaction is taken when start is high and busy is low; every transaction gives
// exactly one result, shown for one cycle with o_done high, and the receiver cannot stall
// it. A deposit runs two registered multiplies (scaling to a cell and splitting the
// weight) and then a read-modify-write of two neighbouring bins through the single
// density RAM, the second bin forwarded from the first when both are the same cell.
// A read answers with the bin through the registered RAM read port, a no-operation
// without leaving idle. A clear sweeps the RAM one bin a cycle; the same sweep runs
// after reset, so busy stays high after reset until the sweep ends.
// Configuration writes are taken at any time but should only be made while idle.
module cic_charge_deposit_1d_top #(
    parameter int GRID_CELLS = ccd_pkg::GRID_CELLS_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    // Command channel
    input  wire logic                start,
    output logic                     busy,
    input  wire logic [1:0]          i_command,
    input  wire logic signed [31:0]  i_position,
    input  wire logic signed [31:0]  i_particle_weight,
    input  wire logic [9:0]          i_bin_to_read,
    // Result channel
    output logic                     o_done,
    output logic signed [47:0]       o_bin_value,
    output logic                     o_status,
    // Configuration write port
    input  wire logic                i_cfg_we,
    input  wire logic [1:0]          i_cfg_index,
    input  wire logic [31:0]         i_cfg_wdata
);

    localparam int AW = (GRID_CELLS > 1) ? $clog2(GRID_CELLS) : 1;
    localparam logic [31:0] GRID_LIM  = 32'(GRID_CELLS);
    localparam logic [31:0] GRID_LAST = 32'(GRID_CELLS - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CLEAR,
        S_MUL1,
        S_MUL2,
        S_AMT,
        S_WR_A,
        S_WR_B,
        S_READ
    } t_state;

    t_state r_state;

    // Configuration registers
    logic [10:0] r_cells;
    logic [31:0] r_inv_w;
    logic [30:0] r_slen;

    // Datapath registers
    logic [30:0]               r_s;
    logic                      r_neg;
    logic [31:0]               r_w;
    logic [62:0]               r_prod;
    logic [31:0]               r_pn;
    logic [AW-1:0]             r_cell;
    logic [AW-1:0]             r_nxt;
    logic [33:0]               r_amt_a;
    logic [33:0]               r_amt_b;
    logic [ccd_pkg::BIN_W-1:0] r_fwd;
    logic [AW-1:0]             r_clr_addr;
    logic                      r_clr_cmd;
    logic                      r_rd_ok;

    // RAM ports
    logic                      ram_we;
    logic [AW-1:0]             ram_waddr;
    logic [ccd_pkg::BIN_W-1:0] ram_wdata;
    logic [AW-1:0]             ram_raddr;
    logic [ccd_pkg::BIN_W-1:0] ram_rdata;

    // Combinational datapath
    logic                      accept;
    logic [32:0]               shift_pos;
    logic [62:0]               prod_comb;
    logic [31:0]               cell_w;
    logic                      cell_oob;
    logic signed [64:0]        pn_full;
    logic [31:0]               nxt_w;
    logic [31:0]               limit_w;
    logic [AW-1:0]             nxt_idx;
    logic [31:0]               rd_ext;
    logic [ccd_pkg::BIN_W-1:0] old_b;
    logic [ccd_pkg::BIN_W-1:0] sum_a;
    logic [ccd_pkg::BIN_W-1:0] sum_b;

    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;

    // Position shifted by the system length when negative; bit 32 flags a drop.
    assign shift_pos = {i_position[31], i_position}
                     + (i_position[31] ? {2'b00, r_slen} : 33'd0);

    // Scaling product and cell extraction.
    assign prod_comb = r_s * r_inv_w;
    assign cell_w    = {1'b0, r_prod[62:32]};
    assign cell_oob  = (cell_w >= GRID_LIM);

    // Weight times fraction; its floor after shifting by 32 is the next-cell part.
    assign pn_full = $signed(r_w) * $signed({1'b0, r_prod[31:0]});

    // Neighbour cell with periodic wrap at the cells in use.
    assign limit_w = (32'(r_cells) > GRID_LIM) ? GRID_LIM : 32'(r_cells);
    assign nxt_w   = 32'(r_cell) + 32'd1;
    assign nxt_idx = (nxt_w >= limit_w) ? '0 : nxt_w[AW-1:0];

    assign rd_ext = 32'(i_bin_to_read);

    // Bin updates, the second forwarded when both parts land in one cell.
    assign old_b = (r_nxt == r_cell) ? r_fwd : ram_rdata;
    assign sum_a = ccd_pkg::sat_add(ram_rdata, r_amt_a);
    assign sum_b = ccd_pkg::sat_add(old_b, r_amt_b);

    // RAM address and write selection.
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_cell;
        ram_wdata = sum_a;
        ram_raddr = r_cell;
        case (r_state)
            S_IDLE: begin
                ram_raddr = rd_ext[AW-1:0];
            end
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr_addr;
                ram_wdata = '0;
            end
            S_WR_A: begin
                ram_we    = 1'b1;
                ram_raddr = r_nxt;
            end
            S_WR_B: begin
                ram_we    = 1'b1;
                ram_waddr = r_nxt;
                ram_wdata = sum_b;
            end
            default: begin
                ram_raddr = r_cell;
            end
        endcase
    end

    ccd_density_ram #(
        .DEPTH (GRID_CELLS),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cells <= ccd_pkg::CELLS_RST;
            r_inv_w <= ccd_pkg::INV_W_RST;
            r_slen  <= ccd_pkg::SLEN_RST;
        end else if (i_cfg_we) begin
            case (ccd_pkg::t_cfg_index'(i_cfg_index))
                ccd_pkg::CFG_CELLS_IN_USE:  r_cells <= i_cfg_wdata[10:0];
                ccd_pkg::CFG_INV_CELL_W:    r_inv_w <= i_cfg_wdata;
                ccd_pkg::CFG_SYSTEM_LENGTH: r_slen  <= i_cfg_wdata[30:0];
                default: ;
            endcase
        end
    end

    // Sequencer with registered result outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_addr <= '0;
            r_clr_cmd  <= 1'b0;
            o_done     <= 1'b0;
        end else begin
            o_done <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        o_bin_value <= '0;
                        o_status    <= ccd_pkg::STATUS_OK;
                        case (ccd_pkg::t_cmd'(i_command))
                            ccd_pkg::CMD_CLEAR: begin
                                r_clr_addr <= '0;
                                r_clr_cmd  <= 1'b1;
                                r_state    <= S_CLEAR;
                            end
                            ccd_pkg::CMD_DEPOSIT: begin
                                r_s     <= shift_pos[30:0];
                                r_neg   <= shift_pos[32];
                                r_w     <= i_particle_weight;
                                r_state <= S_MUL1;
                            end
                            ccd_pkg::CMD_READ: begin
                                r_rd_ok <= (rd_ext < GRID_LIM);
                                r_state <= S_READ;
                            end
                            default: begin
                                o_done <= 1'b1;
                            end
                        endcase
                    end
                end
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                    if (32'(r_clr_addr) == GRID_LAST) begin
                        o_done    <= r_clr_cmd;
                        r_clr_cmd <= 1'b0;
                        r_state   <= S_IDLE;
                    end
                end
                S_MUL1: begin
                    r_prod  <= prod_comb;
                    r_state <= S_MUL2;
                end
                S_MUL2: begin
                    r_cell <= cell_w[AW-1:0];
                    r_pn   <= pn_full[63:32];
                    if (r_neg || cell_oob) begin
                        o_done   <= 1'b1;
                        o_status <= ccd_pkg::STATUS_DROPPED;
                        r_state  <= S_IDLE;
                    end else begin
                        r_state <= S_AMT;
                    end
                end
                S_AMT: begin
                    r_amt_a <= {{2{r_w[31]}}, r_w} - {{2{r_pn[31]}}, r_pn};
                    r_amt_b <= {{2{r_pn[31]}}, r_pn};
                    r_nxt   <= nxt_idx;
                    r_state <= S_WR_A;
                end
                S_WR_A: begin
                    r_fwd   <= sum_a;
                    r_state <= S_WR_B;
                end
                S_WR_B: begin
                    o_done  <= 1'b1;
                    r_state <= S_IDLE;
                end
                S_READ: begin
                    o_bin_value <= r_rd_ok ? ram_rdata : '0;
                    o_done      <= 1'b1;
                    r_state     <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Checks on the sequencer.
`include "cic_charge_deposit_1d_top_assert.svh"

    `CCD_ASSERT_NEXT(a_accept_progress, i_clk, i_rst_n, accept, busy || o_done, "accepted transaction neither in progress nor answered")
    `CCD_ASSERT_SAME(a_drop_zero_value, i_clk, i_rst_n, o_done && o_status, o_bin_value == '0, "dropped particle reported with a bin value")
    `CCD_ASSERT_SAME(a_no_write_idle, i_clk, i_rst_n, ram_we, r_state != S_IDLE, "density RAM written while idle")
    `CCD_ASSERT_NEXT(a_status_deposit, i_clk, i_rst_n, accept && i_command != ccd_pkg::CMD_DEPOSIT, !o_status, "status raised for a non-deposit transaction")

endmodule

`default_nettype wire

>>> rtl/ccd_density_ram.sv
// Single-clock density RAM, one write port and one registered read port.
// Depends on ccd_pkg for the bin width.
`default_nettype none

module ccd_density_ram #(
    parameter int DEPTH = ccd_pkg::GRID_CELLS_DEF,
    parameter int AW    = 10
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_we,
    input  wire logic [AW-1:0]              i_waddr,
    input  wire logic [ccd_pkg::BIN_W-1:0]  i_wdata,
    input  wire logic [AW-1:0]              i_raddr,
    output logic      [ccd_pkg::BIN_W-1:0]  o_rdata
);

    logic [ccd_pkg::BIN_W-1:0] r_mem [DEPTH];

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port; returns the old contents on a same-address write.
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire
